// ===== hw/rtl/huffman_code_bit_packer_macros.svh =====
// assertion macros for the huffman code bit packer
// all checks are sampled on clk and switched off while arst_n is low
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// same-cycle implication
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared widths, request codes and parameter defaults of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int BYTE_W           = 8;
	localparam int PATTERN_W        = 32;
	localparam int LEN_W            = 6;
	localparam int SYM_W            = 8;
	localparam int REQ_W            = 2;
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int SYMBOL_COUNT_DEF = 256;

	typedef logic [REQ_W-1:0] req_type_t;

	localparam req_type_t REQ_LOAD   = 2'd0;
	localparam req_type_t REQ_ENCODE = 2'd1;
	localparam req_type_t REQ_FLUSH  = 2'd2;

endpackage

// ===== hw/rtl/hcbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_if
// Valid/ready channels of the code bit packer: requests in, bytes out.
// ----------------------------------------------------------------------------
interface hcbp_req_if;
	import hcbp_pkg::*;

	logic                 valid;
	logic                 ready;
	req_type_t            req_type;
	logic [SYM_W-1:0]     symbol;
	logic [LEN_W-1:0]     code_length;
	logic [PATTERN_W-1:0] code_bits;

	modport source (output valid, output req_type, output symbol, output code_length,
		output code_bits, input ready);
	modport sink (input valid, input req_type, input symbol, input code_length,
		input code_bits, output ready);
endinterface

interface hcbp_byte_if;
	import hcbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// a request beat is held in the request stage, then its bytes in the byte register
// throughput: one request per cycle while each request yields at most one byte and stream.ready is high;
// a request that completes n bytes holds the byte register for n output beats
// (the single byte register is the limit, up to four bytes per symbol)
// reset: code valid bits, pending bits and pipeline valids clear at once, no sweep
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Code table plus lsb-first bit packer: load, encode and flush requests.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_macros.svh"

module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	hcbp_req_if.sink           req,
	hcbp_byte_if.source        stream
);
	import hcbp_pkg::*;

	localparam int IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_CAP  = (MAX_CODE_LEN < PATTERN_W) ? MAX_CODE_LEN : PATTERN_W;
	localparam int ACC_W    = PATTERN_W + BYTE_W - 1;
	localparam int PEND_W   = BYTE_W - 1;
	localparam int CNT_W    = $clog2(BYTE_W);
	localparam int NB_W     = LEN_W - CNT_W;

	localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
	localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

	// code table
	logic [LEN_W-1:0]     len_mem [SYMBOL_COUNT];
	logic [PATTERN_W-1:0] pat_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] code_vld_q;

	// request stage
	logic                 valid_s1;
	req_type_t            req_type_s1;
	logic                 sym_ok_s1;
	logic                 code_vld_s1;
	logic [LEN_W-1:0]     len_s1;
	logic [PATTERN_W-1:0] pat_s1;

	// byte register
	logic [PATTERN_W-1:0] obuf_s2;
	logic [NB_W-1:0]      left_s2;

	logic [PEND_W-1:0]    pend_bits_q;
	logic [CNT_W-1:0]     pend_cnt_q;

	logic                 in_fire;
	logic                 out_fire;
	logic                 s2_free;
	logic                 adv1;
	logic                 sym_ok;
	logic [IDX_W-1:0]     idx;
	logic [LEN_W-1:0]     ld_len;
	logic [PATTERN_W-1:0] ld_mask;

	logic [LEN_W-1:0]     eff_len;
	logic [ACC_W-1:0]     acc;
	logic [ACC_W-1:0]     acc_rest;
	logic [LEN_W-1:0]     total;
	logic [NB_W-1:0]      nbytes;
	logic [PATTERN_W-1:0] emit_buf;
	logic [PEND_W-1:0]    nxt_bits;
	logic [CNT_W-1:0]     nxt_cnt;

	assign in_fire  = req.valid && req.ready;
	assign out_fire = stream.valid && stream.ready;
	assign s2_free  = (left_s2 == '0) || ((left_s2 == NB_W'(1)) && stream.ready);
	assign adv1     = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;

	assign sym_ok  = {1'b0, req.symbol} < SYM_LIMIT;
	assign idx     = req.symbol[IDX_W-1:0];
	assign ld_len  = (req.code_length > LEN_CAP_V) ? LEN_CAP_V : req.code_length;
	// a shift of the full width or more gives zero, so a 32-bit length masks nothing
	assign ld_mask = ~({PATTERN_W{1'b1}} << ld_len);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (req.req_type == REQ_LOAD && sym_ok) begin
				len_mem[idx] <= ld_len;
				pat_mem[idx] <= req.code_bits & ld_mask;
			end else begin
				len_s1 <= len_mem[idx];
				pat_s1 <= pat_mem[idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_vld_q <= '0;
		end else if (in_fire && req.req_type == REQ_LOAD && sym_ok) begin
			code_vld_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1 <= req.req_type;
			sym_ok_s1   <= sym_ok;
			code_vld_s1 <= code_vld_q[idx];
		end
	end

	always_comb begin
		eff_len  = code_vld_s1 ? len_s1 : '0;
		acc      = (ACC_W'(pat_s1) << pend_cnt_q) | ACC_W'(pend_bits_q);
		total    = LEN_W'(pend_cnt_q) + eff_len;
		acc_rest = acc >> {total[LEN_W-1:CNT_W], {CNT_W{1'b0}}};
		nbytes   = '0;
		emit_buf = '0;
		nxt_bits = pend_bits_q;
		nxt_cnt  = pend_cnt_q;
		case (req_type_s1)
			REQ_ENCODE: begin
				if (sym_ok_s1 && eff_len != '0) begin
					nbytes   = total[LEN_W-1:CNT_W];
					emit_buf = acc[PATTERN_W-1:0];
					nxt_bits = acc_rest[PEND_W-1:0];
					nxt_cnt  = total[CNT_W-1:0];
				end
			end
			REQ_FLUSH: begin
				if (pend_cnt_q != '0) begin
					nbytes   = NB_W'(1);
					emit_buf = PATTERN_W'(pend_bits_q);
					nxt_bits = '0;
					nxt_cnt  = '0;
				end
			end
			default: begin
				nbytes = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (adv1) begin
			pend_bits_q <= nxt_bits;
			pend_cnt_q  <= nxt_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_s2 <= '0;
		end else if (adv1) begin
			left_s2 <= nbytes;
		end else if (out_fire) begin
			left_s2 <= left_s2 - NB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			obuf_s2 <= emit_buf;
		end else if (out_fire) begin
			obuf_s2 <= obuf_s2 >> BYTE_W;
		end
	end

	assign stream.valid       = left_s2 != '0;
	assign stream.out_byte    = obuf_s2[BYTE_W-1:0];
	assign stream.last_of_run = left_s2 == NB_W'(1);

	`HCBP_ASSERT_IMP(a_left_bound, 1'b1, left_s2 <= NB_W'(PATTERN_W / BYTE_W), "byte count too high")
	`HCBP_ASSERT_NXT(a_flush_clears, adv1 && req_type_s1 == REQ_FLUSH, pend_cnt_q == '0, "flush left bits")
	`HCBP_ASSERT_NXT(a_run_continues, out_fire && left_s2 > NB_W'(1), stream.valid, "byte run broken")
	`HCBP_ASSERT_NXT(a_s1_holds, valid_s1 && !adv1, valid_s1, "request stage dropped an item")

endmodule

// ===== tb/tb_huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer
// Drives load, encode and flush requests into the code bit packer, predicts
// packed bytes from typed rows or a local model of code table and accumulator,
// and checks each output beat in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer;
	import hcbp_pkg::*;

	localparam req_type_t REQ_SPARE = 2'd3;
	localparam int        CODE_CAP  = (MAX_CODE_LEN_DEF < PATTERN_W) ? MAX_CODE_LEN_DEF : PATTERN_W;
	localparam int        RANDOM_ITEMS = 346;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              last;
	} byte_exp_t;

	typedef struct {
		req_type_t            kind;
		logic [SYM_W-1:0]     sym;
		logic [LEN_W-1:0]     len;
		logic [PATTERN_W-1:0] bits;
		bit                   typed;
		int                   n_typed;
		logic [31:0]          typed_data;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hcbp_req_if  req_ch ();
	hcbp_byte_if byte_ch ();

	huffman_code_bit_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.stream (byte_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAIL huffman_code_bit_packer");
		$finish;
	end

	// local copy of the code table and the bit accumulator
	logic [LEN_W-1:0]     code_len [256];
	logic [PATTERN_W-1:0] code_pat [256];
	logic [6:0]           pend_bits;
	logic [2:0]           pend_cnt;
	byte_exp_t            pred_out [4];

	byte_exp_t bytes_due [$];
	byte_exp_t due;
	int        err_cnt = 0;
	int        bytes_checked = 0;
	int        n_load = 0, n_encode = 0, n_flush = 0, n_spare = 0;
	bit        src_burst = 1'b0;
	bit        sink_burst = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// bytes completed by one request beat, also advances the local state
	function automatic int pack_bytes(input req_type_t kind, input logic [SYM_W-1:0] sym,
		input logic [LEN_W-1:0] len_in, input logic [PATTERN_W-1:0] bits_in);
		logic [LEN_W-1:0] len;
		logic [32:0]      mask;
		logic [63:0]      acc;
		int               total;
		int               n;
		n = 0;
		case (kind)
			REQ_LOAD: begin
				len = (len_in > CODE_CAP) ? LEN_W'(CODE_CAP) : len_in;
				mask = (33'd1 << len) - 33'd1;
				code_len[sym] = len;
				code_pat[sym] = bits_in & mask[31:0];
			end
			REQ_ENCODE: begin
				if (code_len[sym] != 0) begin
					acc = 64'(pend_bits) | (64'(code_pat[sym]) << pend_cnt);
					total = int'(pend_cnt) + int'(code_len[sym]);
					while (total >= BYTE_W) begin
						pred_out[n] = '{acc[7:0], 1'b0};
						n++;
						acc = acc >> BYTE_W;
						total -= BYTE_W;
					end
					if (n > 0)
						pred_out[n-1].last = 1'b1;
					pend_bits = acc[6:0];
					pend_cnt = 3'(total);
				end
			end
			REQ_FLUSH: begin
				if (pend_cnt != 0) begin
					pred_out[0] = '{{1'b0, pend_bits}, 1'b1};
					n = 1;
					pend_bits = '0;
					pend_cnt = '0;
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	task automatic issue_req(input stim_row_t r);
		int gap;
		int n;
		gap = src_burst ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= r.kind;
		req_ch.symbol      <= r.sym;
		req_ch.code_length <= r.len;
		req_ch.code_bits   <= r.bits;
		do @(posedge clk); while (!req_ch.ready);
		n = pack_bytes(r.kind, r.sym, r.len, r.bits);
		if (r.typed) begin
			for (int k = 0; k < r.n_typed; k++)
				bytes_due.insert(bytes_due.size(),
					'{r.typed_data[8*k +: 8], k == r.n_typed - 1});
		end else begin
			for (int k = 0; k < n; k++)
				bytes_due.insert(bytes_due.size(), pred_out[k]);
		end
		case (r.kind)
			REQ_LOAD:   n_load++;
			REQ_ENCODE: n_encode++;
			REQ_FLUSH:  n_flush++;
			default:    n_spare++;
		endcase
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
	endtask

	// output beat check
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (bytes_due.size() == 0) begin
				$display("%0t: byte %02h last %b arrived with nothing expected",
					$time, byte_ch.out_byte, byte_ch.last_of_run);
				err_cnt++;
			end else begin
				due = bytes_due.pop_front();
				bytes_checked++;
				if (byte_ch.out_byte !== due.data) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$time, due.data, byte_ch.out_byte);
					err_cnt++;
				end
				if (byte_ch.last_of_run !== due.last) begin
					$display("%0t: last_of_run expected %b actual %b",
						$time, due.last, byte_ch.last_of_run);
					err_cnt++;
				end
			end
		end
	end

	// byte sink with random back-pressure
	initial begin
		int stall;
		stall = 0;
		byte_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				sink_burst = !sink_burst;
			if (stall > 0) begin
				byte_ch.ready <= 1'b0;
				stall--;
			end else begin
				byte_ch.ready <= 1'b1;
				if (!sink_burst && $urandom_range(0, 2) == 0)
					stall = pick_gap();
			end
		end
	end

	// directed rows: typed expectations only where they are obvious
	stim_row_t dir_rows [24] = '{
		'{REQ_ENCODE, 8'h00, 6'd0,  32'h0,        1'b1, 0, 32'h0},        // nothing loaded yet
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0,        1'b1, 0, 32'h0},        // nothing pending
		'{REQ_LOAD,   8'hFF, 6'd32, 32'hFFFFFFFF, 1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'hFF, 6'd0,  32'h0,        1'b1, 4, 32'hFFFFFFFF},
		'{REQ_LOAD,   8'h00, 6'd1,  32'hFFFFFFFE, 1'b0, 0, 32'h0},        // upper bits masked
		'{REQ_LOAD,   8'h01, 6'd3,  32'h00000005, 1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'h01, 6'd0,  32'h0,        1'b1, 0, 32'h0},
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0,        1'b1, 1, 32'h05},
		'{REQ_LOAD,   8'hAA, 6'd63, 32'hA5A5A5A5, 1'b0, 0, 32'h0},        // overlong, saturates
		'{REQ_ENCODE, 8'h01, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'hAA, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'h00, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_SPARE,  8'hFF, 6'd32, 32'hFFFFFFFF, 1'b1, 0, 32'h0},        // unused type
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_LOAD,   8'h7F, 6'd0,  32'hFFFFFFFF, 1'b0, 0, 32'h0},        // absent symbol
		'{REQ_ENCODE, 8'h7F, 6'd0,  32'h0,        1'b1, 0, 32'h0},
		'{REQ_LOAD,   8'h80, 6'd8,  32'h000000C3, 1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'h80, 6'd0,  32'h0,        1'b1, 1, 32'hC3},
		'{REQ_LOAD,   8'h55, 6'd33, 32'h12345678, 1'b0, 0, 32'h0},
		'{REQ_LOAD,   8'h01, 6'd7,  32'h0000007F, 1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'h01, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_ENCODE, 8'h55, 6'd0,  32'h0,        1'b0, 0, 32'h0},        // seven pending plus 32
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0,        1'b0, 0, 32'h0},
		'{REQ_FLUSH,  8'h00, 6'd0,  32'h0,        1'b1, 0, 32'h0}
	};

	initial begin
		stim_row_t        r;
		logic [SYM_W-1:0] live_syms [$];
		int               hit [$];
		int               made;
		int               roll;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.symbol = '0;
		req_ch.code_length = '0;
		req_ch.code_bits = '0;
		for (int i = 0; i < 256; i++) begin
			code_len[i] = '0;
			code_pat[i] = '0;
		end
		pend_bits = '0;
		pend_cnt = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			issue_req(dir_rows[i]);
		hold_until_drained();
		for (int i = 0; i < 256; i++)
			if (code_len[i] != 0)
				live_syms.insert(live_syms.size(), SYM_W'(i));

		made = 0;
		while (made < RANDOM_ITEMS) begin
			if (made % 40 == 0)
				src_burst = ($urandom_range(0, 3) == 0);
			if (made == RANDOM_ITEMS / 2)
				hold_until_drained();
			r = '{REQ_ENCODE, '0, '0, '0, 1'b0, 0, 32'h0};
			r.len = LEN_W'($urandom_range(0, 63));
			r.bits = $urandom;
			roll = $urandom_range(0, 99);
			if (live_syms.size() < 4 || (roll >= 55 && roll < 75)) begin
				r.kind = REQ_LOAD;
				r.sym = SYM_W'($urandom_range(0, 255));
				roll = $urandom_range(0, 99);
				if (roll < 70)
					r.len = LEN_W'($urandom_range(1, 10));
				else if (roll < 85)
					r.len = LEN_W'($urandom_range(11, 24));
				else if (roll < 93)
					r.len = LEN_W'($urandom_range(25, 32));
				else if (roll < 97)
					r.len = LEN_W'($urandom_range(33, 63));
				else
					r.len = '0;
				hit = live_syms.find_first_index(x) with (x == r.sym);
				if (r.len == 0 && hit.size() != 0)
					live_syms.delete(hit[0]);
				else if (r.len != 0 && hit.size() == 0)
					live_syms.insert(live_syms.size(), r.sym);
			end else if (roll < 55) begin
				r.sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
			end else if (roll < 88) begin
				r.kind = REQ_FLUSH;
				r.sym = SYM_W'($urandom_range(0, 255));
			end else if (roll < 97) begin
				// any symbol, loaded or not
				r.sym = SYM_W'($urandom_range(0, 255));
			end else begin
				r.kind = REQ_SPARE;
				r.sym = SYM_W'($urandom_range(0, 255));
			end
			issue_req(r);
			if (r.kind != REQ_SPARE)
				made++;
		end

		hold_until_drained();
		repeat (16) @(posedge clk);
		$display("covered %0d loads, %0d encodes, %0d flushes, %0d unused-type beats",
			n_load, n_encode, n_flush, n_spare);
		$display("checked %0d packed bytes, %0d mismatches", bytes_checked, err_cnt);
		if (err_cnt == 0 && bytes_due.size() == 0)
			$display("PASS huffman_code_bit_packer");
		else
			$display("FAIL huffman_code_bit_packer");
		$finish;
	end

endmodule

// ===== huffman_code_bit_packer.f =====
+incdir+hw/rtl
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_if.sv
hw/rtl/huffman_code_bit_packer.sv
tb/tb_huffman_code_bit_packer.sv
